FILE: rtl/core/calendar_to_epoch_seconds_defines.svh
// Assertion macros used by the checker of the calendar converter
`ifndef CALENDAR_TO_EPOCH_SECONDS_DEFINES_SVH
`define CALENDAR_TO_EPOCH_SECONDS_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low
`define CTES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define CTES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ctes_pkg.sv
// Types, constants and calendar tables of the calendar-to-epoch converter
package ctes_pkg;

  localparam logic [15:0] YEAR_MIN     = 16'd2008;
  localparam logic [15:0] YEAR_MAX     = 16'd2100;
  localparam int          EPOCH_YEAR   = 1970;
  localparam int          LEAP_ANCHOR  = 1968;   // a leap year on or before the epoch
  localparam int          SKIP_YEAR    = 2100;   // century year that is not a leap year
  localparam logic [4:0]  HOUR_MAX     = 5'd25;
  localparam logic [5:0]  MINSEC_MAX   = 6'd61;
  localparam logic [5:0]  MINSEC_WRAP  = 6'd60;
  localparam logic [5:0]  HOUR_WRAP    = 6'd24;
  localparam logic [3:0]  MONTH_LAST   = 4'd11;
  localparam int          ROLL_STEPS   = 3;
  localparam logic [32:0] DAY_SECONDS  = 33'd86400;
  localparam logic [32:0] TOTAL_MAX    = 33'd2147483647;

  // Year offsets from YEAR_MIN
  localparam logic [6:0]  SKIP_OFF     = 7'(SKIP_YEAR - 2008);
  localparam logic [7:0]  YEARS_BASE   = 8'(2008 - EPOCH_YEAR);
  localparam logic [7:0]  LEAP_BASE    = 8'(2008 - 1 - LEAP_ANCHOR);

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } in_t;

  // Date with the time of day carried and normalised
  typedef struct packed {
    logic       ok;
    logic [6:0] yoff;   // year - YEAR_MIN
    logic [3:0] mon;    // 0..11
    logic [4:0] day;    // 0-based day, may still pass the month end
    logic [4:0] hr;
    logic [5:0] mi;
    logic [5:0] se;
  } date_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] days;  // days since the epoch
    logic [16:0] tod;   // seconds into the day
  } count_t;

  function automatic logic leap_of(input logic [6:0] yoff);
    return (yoff[1:0] == 2'd0) && (yoff != SKIP_OFF);
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1:                 len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default:              len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before_month(input logic leap, input logic [3:0] m);
    logic [8:0] base;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      default: base = 9'd334;
    endcase
    return ((m > 4'd1) && leap) ? base + 9'd1 : base;
  endfunction

endpackage

FILE: rtl/core/ctes_ifs.sv
// Handshake channels of the calendar-to-epoch converter
interface ctes_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport source (output valid, year, month, day_of_month, hour, minute, second,
                  input ready);
  modport sink   (input valid, year, month, day_of_month, hour, minute, second,
                  output ready);
endinterface

interface ctes_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] epoch_seconds;

  modport source (output valid, epoch_seconds, input ready);
  modport sink   (input valid, epoch_seconds, output ready);
endinterface

FILE: rtl/core/ctes_front.sv
// First stage: range check and carry of seconds, minutes and hours
module ctes_front
  import ctes_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  vld_i,
  output logic  rdy_o,
  input  in_t   data_i,
  output logic  vld_o,
  input  logic  rdy_i,
  output date_t data_o
);

  logic  vld_r;
  date_t data_r;
  date_t data_nxt;

  always_comb begin
    logic       se_c;
    logic       mi_c;
    logic       hr_c;
    logic [6:0] mi_s;
    logic [5:0] hr_s;

    se_c = data_i.second >= MINSEC_WRAP;
    mi_s = 7'(data_i.minute) + 7'(se_c);
    mi_c = mi_s >= 7'(MINSEC_WRAP);
    hr_s = 6'(data_i.hour) + 6'(mi_c);
    hr_c = hr_s >= HOUR_WRAP;

    data_nxt.ok   = (data_i.year >= YEAR_MIN) && (data_i.year <= YEAR_MAX) &&
                    (data_i.month >= 4'd1) && (data_i.month <= 4'd12) &&
                    (data_i.day_of_month != 5'd0) && (data_i.hour <= HOUR_MAX) &&
                    (data_i.minute <= MINSEC_MAX) && (data_i.second <= MINSEC_MAX);
    data_nxt.yoff = 7'(data_i.year - YEAR_MIN);
    data_nxt.mon  = data_i.month - 4'd1;
    data_nxt.day  = data_i.day_of_month - 5'd1 + 5'(hr_c);
    data_nxt.se   = se_c ? data_i.second - MINSEC_WRAP : data_i.second;
    data_nxt.mi   = mi_c ? 6'(mi_s - 7'(MINSEC_WRAP)) : 6'(mi_s);
    data_nxt.hr   = hr_c ? 5'(hr_s - HOUR_WRAP) : 5'(hr_s);
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_i && rdy_o) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

FILE: rtl/core/ctes_roll.sv
// Second stage: roll the day over month and year ends
module ctes_roll
  import ctes_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  vld_i,
  output logic  rdy_o,
  input  date_t data_i,
  output logic  vld_o,
  input  logic  rdy_i,
  output date_t data_o
);

  logic  vld_r;
  date_t data_r;
  date_t data_nxt;

  // Once a step finds the day inside its month the later steps change nothing
  always_comb begin
    logic [4:0] len;
    data_nxt = data_i;
    for (int i = 0; i < ROLL_STEPS; i++) begin
      len = month_len(leap_of(data_nxt.yoff), data_nxt.mon);
      if (data_nxt.day >= len) begin
        data_nxt.day = data_nxt.day - len;
        if (data_nxt.mon == MONTH_LAST) begin
          data_nxt.mon  = 4'd0;
          data_nxt.yoff = data_nxt.yoff + 7'd1;
        end else begin
          data_nxt.mon = data_nxt.mon + 4'd1;
        end
      end
    end
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_i && rdy_o) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

FILE: rtl/core/ctes_days.sv
// Third stage: day count since the epoch and seconds into the day
module ctes_days
  import ctes_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   vld_i,
  output logic   rdy_o,
  input  date_t  data_i,
  output logic   vld_o,
  input  logic   rdy_i,
  output count_t data_o
);

  logic   vld_r;
  count_t data_r;
  count_t data_nxt;

  always_comb begin
    logic [7:0]  yrs;
    logic [7:0]  leaps;
    logic [15:0] yr_days;
    logic [8:0]  mon_days;

    yrs      = 8'(data_i.yoff) + YEARS_BASE;
    // Leap years from the epoch up to the year before; the skipped century
    // only counts against a year that follows it
    leaps    = ((8'(data_i.yoff) + LEAP_BASE) >> 2) -
               8'(data_i.yoff > SKIP_OFF);
    yr_days  = 16'(yrs) * 16'd365;
    mon_days = days_before_month(leap_of(data_i.yoff), data_i.mon);

    data_nxt.ok   = data_i.ok;
    data_nxt.days = yr_days + 16'(leaps) + 16'(mon_days) + 16'(data_i.day);
    data_nxt.tod  = 17'(data_i.hr) * 17'd3600 + 17'(data_i.mi) * 17'd60 +
                    17'(data_i.se);
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_i && rdy_o) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

FILE: rtl/core/ctes_scale.sv
// Last stage: scale days to seconds, give zero on overflow, hold the output word
module ctes_scale
  import ctes_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        vld_i,
  output logic        rdy_o,
  input  count_t      data_i,
  output logic        vld_o,
  input  logic        rdy_i,
  output logic [30:0] secs_o
);

  logic        vld_r;
  logic [30:0] secs_r;
  logic [30:0] secs_nxt;
  logic [32:0] total;

  assign total    = 33'(data_i.days) * DAY_SECONDS + 33'(data_i.tod);
  assign secs_nxt = (data_i.ok && (total <= TOTAL_MAX)) ? total[30:0] : '0;

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_i && rdy_o) begin
      secs_r <= secs_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign secs_o = secs_r;

endmodule

FILE: rtl/core/calendar_to_epoch_seconds.sv
// Top level of the calendar date and time to epoch seconds converter
//
// Usage:
//   in_ch carries one calendar word per handshake: year, month, day_of_month,
//   hour, minute and second. out_ch returns one word per input word: the
//   count of seconds since 1970-01-01 00:00:00, or zero when a field is out
//   of range or the instant lies beyond the 31-bit limit in January 2038.
//   A word moves on a rising clk edge with valid and ready both high.
// Pipeline and throughput:
//   a taken word passes the four pipeline registers (carry, month roll, day
//   count, scale) in that order to out_ch, and each holds one word; one word
//   per cycle sustained while out_ch.ready stays high.
// Reset:
//   rst_n low at a clk edge empties every stage; nothing else is kept.
// Back-pressure:
//   out_ch.ready low holds the output word; each stage still takes a word
//   while its own register is empty, so bubbles close up before in_ch
//   stalls, and no word is dropped or repeated.
module calendar_to_epoch_seconds
  import ctes_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  ctes_in_if.sink           in_ch,
  ctes_out_if.source        out_ch
);

  in_t    in_word;
  logic   s1_vld;
  logic   s1_rdy;
  date_t  s1_data;
  logic   s2_vld;
  logic   s2_rdy;
  date_t  s2_data;
  logic   s3_vld;
  logic   s3_rdy;
  count_t s3_data;

  // Gather the channel fields into one word
  assign in_word = '{year:         in_ch.year,
                     month:        in_ch.month,
                     day_of_month: in_ch.day_of_month,
                     hour:         in_ch.hour,
                     minute:       in_ch.minute,
                     second:       in_ch.second};

  // Validate and carry the time of day
  ctes_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (in_ch.valid),
    .rdy_o  (in_ch.ready),
    .data_i (in_word),
    .vld_o  (s1_vld),
    .rdy_i  (s1_rdy),
    .data_o (s1_data)
  );

  // Roll the day past month ends
  ctes_roll u_roll (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s1_vld),
    .rdy_o  (s1_rdy),
    .data_i (s1_data),
    .vld_o  (s2_vld),
    .rdy_i  (s2_rdy),
    .data_o (s2_data)
  );

  // Count days since the epoch and seconds into the day
  ctes_days u_days (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s2_vld),
    .rdy_o  (s2_rdy),
    .data_i (s2_data),
    .vld_o  (s3_vld),
    .rdy_i  (s3_rdy),
    .data_o (s3_data)
  );

  // Scale to seconds and hold the result word
  ctes_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s3_vld),
    .rdy_o  (s3_rdy),
    .data_i (s3_data),
    .vld_o  (out_ch.valid),
    .rdy_i  (out_ch.ready),
    .secs_o (out_ch.epoch_seconds)
  );

endmodule

FILE: rtl/core/ctes_checker.sv
// Port-level checker of the calendar-to-epoch converter, with its bind
`include "calendar_to_epoch_seconds_defines.svh"

module ctes_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [30:0] out_epoch_seconds
);

  // An empty output register leaves room all the way back to the input
  `CTES_ASSERT_NOW(a_empty_takes, !out_valid, in_ready, "input stalled with empty output")

  // A draining output lets every stage advance
  `CTES_ASSERT_NOW(a_drain_takes, out_ready, in_ready, "input stalled while output drains")

  // A stalled result stays offered and unchanged
  `CTES_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid, "result withdrawn")
  `CTES_ASSERT_NEXT(a_hold_word, out_valid && !out_ready, $stable(out_epoch_seconds),
    "stalled result changed")

endmodule

bind calendar_to_epoch_seconds ctes_checker u_ctes_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_epoch_seconds (out_ch.epoch_seconds)
);
